// ===== hdl/byte_ring_fifo_burst_top_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef BYTE_RING_FIFO_BURST_TOP_MACROS_SVH
`define BYTE_RING_FIFO_BURST_TOP_MACROS_SVH

// Same-cycle implication.
`define BRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring fifo: assertion failed");

// Next-cycle implication.
`define BRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring fifo: assertion failed");

`endif

// ===== hdl/brf_pkg.sv =====
package brf_pkg;

    localparam int DEPTH_DEF     = 4096;
    localparam int MAX_BYTES_DEF = 8;

    localparam int CFG_W  = 13;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int FILL_W = 12;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic              op;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] write_bytes;
    } req_item_t;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] read_bytes;
        logic [FILL_W-1:0] fill_level;
    } rsp_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic decide;    // register accept/refuse verdict
        logic wr_en;     // write one byte at head
        logic rd_en;     // read one byte at tail
        logic out_load;  // load response register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic refuse;    // current request cannot be served
        logic zero_len;  // nothing to move
        logic op;        // operation of current request
        logic last;      // this byte is the final one
    } sts_t;

endpackage

// ===== hdl/brf_ctrl.sv =====
module brf_ctrl
    import brf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_WR     = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.refuse || sts.zero_len)
                    state_next = S_FIN;
                else if (sts.op == OP_READ)
                    state_next = S_RD;
                else
                    state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr_en = 1'b1;
                if (sts.last)
                    state_next = S_FIN;
            end
            S_RD:
            begin
                cmd.rd_en = 1'b1;
                if (sts.last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_FIN;
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign rsp_valid_next = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== hdl/brf_datapath.sv =====
module brf_datapath
    import brf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  req_item_t        req,
    output rsp_item_t        rsp,
    input  cmd_t             cmd,
    output sts_t             sts
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SZ_W   = $clog2(DEPTH + 1);
    localparam int SUM_W  = SZ_W + LEN_W;
    localparam int LANE_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    logic [7:0] mem [DEPTH];

    logic [SZ_W-1:0]   size_reg, size_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [LANE_W-1:0] cnt_reg, cnt_next;
    logic              rvalid_q_reg;
    logic [LANE_W-1:0] lane_q_reg;
    logic [7:0]        mem_q_reg;

    logic              op_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              refused_reg;
    rsp_item_t         rsp_reg;

    logic [SZ_W-1:0]  fill_wide;
    logic [PTR_W-1:0] fill;
    logic [SUM_W-1:0] want;
    logic [SZ_W-1:0]  head_inc, tail_inc;
    logic [31:0]      ring_req;
    logic             refuse;

    // clamp requested ring size to 2..DEPTH
    always_comb
    begin
        ring_req = 32'(cfg_wdata);
        priority if (ring_req < 32'd2)
            size_next = SZ_W'(2);
        else if (ring_req > 32'(DEPTH))
            size_next = SZ_W'(DEPTH);
        else
            size_next = SZ_W'(ring_req);
    end

    always_comb
    begin
        if (head_reg >= tail_reg)
            fill_wide = SZ_W'(head_reg) - SZ_W'(tail_reg);
        else
            fill_wide = SZ_W'(head_reg) + size_reg - SZ_W'(tail_reg);
        fill = PTR_W'(fill_wide);
    end

    assign want = SUM_W'(fill) + SUM_W'(len_reg);

    always_comb
    begin
        if (len_reg > LEN_W'(MAX_BYTES))
            refuse = 1'b1;
        else if (op_reg == OP_WRITE)
            refuse = want > (SUM_W'(size_reg) - SUM_W'(1));
        else
            refuse = SUM_W'(len_reg) > SUM_W'(fill);
    end

    assign sts.refuse   = refuse;
    assign sts.zero_len = (len_reg == '0);
    assign sts.op       = op_reg;
    assign sts.last     = (LEN_W'(cnt_reg) == len_reg - LEN_W'(1));

    // pointer wrap at ring size
    assign head_inc  = SZ_W'(head_reg) + SZ_W'(1);
    assign tail_inc  = SZ_W'(tail_reg) + SZ_W'(1);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
            cnt_next = '0;
        if (cmd.wr_en)
        begin
            head_next = (head_inc >= size_reg) ? '0 : PTR_W'(head_inc);
            cnt_next  = cnt_reg + LANE_W'(1);
        end
        if (cmd.rd_en)
        begin
            tail_next = (tail_inc >= size_reg) ? '0 : PTR_W'(tail_inc);
            cnt_next  = cnt_reg + LANE_W'(1);
        end
        if (cfg_we)
        begin
            head_next = '0;
            tail_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SZ_W'(DEPTH);
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            rvalid_q_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= size_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
            rvalid_q_reg <= cmd.rd_en;
        end
    end

    // byte store, one access per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[head_reg] <= wdata_reg[8*cnt_reg +: 8];
        if (cmd.rd_en)
            mem_q_reg <= mem[tail_reg];
    end

    always_ff @(posedge clk)
    begin
        lane_q_reg <= cnt_reg;
        if (cmd.load)
        begin
            op_reg    <= req.op;
            len_reg   <= req.length;
            wdata_reg <= req.write_bytes;
            rdata_reg <= '0;
        end
        else if (rvalid_q_reg)
            rdata_reg[8*lane_q_reg +: 8] <= mem_q_reg;
        if (cmd.decide)
            refused_reg <= refuse;
        if (cmd.out_load)
        begin
            rsp_reg.status     <= refused_reg ? ST_REFUSED : ST_DONE;
            rsp_reg.read_bytes <= refused_reg ? '0 : rdata_reg;
            rsp_reg.fill_level <= FILL_W'(fill);
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hdl/byte_ring_fifo_burst_top.sv =====
// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  -------------------------------
// req       in   req_valid / req_ready  req_item_t (op, length, write_bytes)
// rsp       out  rsp_valid / rsp_ready  rsp_item_t (status, read_bytes, fill_level)
// cfg       in   cfg_we                 cfg_wdata (ring_size)
//
// One transaction at a time; bytes move one per cycle through the single-port byte store.
// Write: accept, decide, move the n bytes, publish; a read also drains the store read.
// A refused or zero-length transaction skips the byte moves.
// Reset (rst_n, async, low): pointers zero, ring size DEPTH; store contents are not cleared.
// A stalled response holds in the output register; the next request is taken meanwhile.
module byte_ring_fifo_burst_top
    import brf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_item_t        req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_item_t        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    `include "byte_ring_fifo_burst_top_macros.svh"

    cmd_t cmd;
    sts_t sts;

    // Sequencer: accept, decide, move bytes, publish result.
    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Pointers, byte store, fill arithmetic and response register.
    brf_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Accepting a transaction makes the block busy.
    `BRF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    // Store never written and read in the same cycle.
    `BRF_ASSERT_NOW(a_one_access, cmd.wr_en, !cmd.rd_en)
    // A pending response is never overwritten.
    `BRF_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid || rsp_ready)
    // Byte moves only happen while no request is being taken.
    `BRF_ASSERT_NOW(a_move_busy, cmd.wr_en || cmd.rd_en, !req_ready)

endmodule

// ===== sim/byte_ring_fifo_burst_top_tb.sv =====
module byte_ring_fifo_burst_top_tb;
    import brf_pkg::*;

    // Run limits.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int LONG_HOLD   = 300;
    // Settling time after the last response.
    localparam int SETTLE      = 16;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_item_t        req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_item_t        rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    byte_ring_fifo_burst_top #(
        .DEPTH     (DEPTH_DEF),
        .MAX_BYTES (MAX_BYTES_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Ring predictor: own copy of ring size, pointers and byte store.
    // Pointers always stay below the effective ring size, since they are
    // cleared on every ring size write and wrap at that size.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] ring_cfg;
    int unsigned      head_ptr;
    int unsigned      tail_ptr;
    logic [7:0]       ring_bytes [DEPTH_DEF];

    // Out-of-range sizes clamp to 2 .. DEPTH.
    function automatic int unsigned ring_slots();
        if (ring_cfg < 2)
            return 2;
        if (ring_cfg > DEPTH_DEF)
            return DEPTH_DEF;
        return ring_cfg;
    endfunction

    function automatic int unsigned ring_fill(int unsigned slots);
        return (head_ptr >= tail_ptr) ? head_ptr - tail_ptr : head_ptr + slots - tail_ptr;
    endfunction

    // Applies one transaction to the predicted ring and returns its response.
    function automatic rsp_item_t ring_transfer(req_item_t t);
        int unsigned slots;
        int unsigned fill;
        int unsigned n;
        rsp_item_t   r;
        slots        = ring_slots();
        fill         = ring_fill(slots);
        n            = t.length;
        r.status     = ST_DONE;
        r.read_bytes = '0;
        if (n > MAX_BYTES_DEF)
        begin
            r.status = ST_REFUSED;
        end
        else if (t.op == OP_WRITE)
        begin
            // one slot always stays empty
            if (fill + n > slots - 1)
            begin
                r.status = ST_REFUSED;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    ring_bytes[head_ptr] = t.write_bytes[8*i +: 8];
                    head_ptr = (head_ptr + 1 >= slots) ? 0 : head_ptr + 1;
                end
            end
        end
        else
        begin
            if (n > fill)
            begin
                r.status = ST_REFUSED;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    r.read_bytes[8*i +: 8] = ring_bytes[tail_ptr];
                    tail_ptr = (tail_ptr + 1 >= slots) ? 0 : tail_ptr + 1;
                end
            end
        end
        r.fill_level = FILL_W'(ring_fill(slots));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Queues and counters shared by the stimulus, driver and monitor.
    // ------------------------------------------------------------------
    req_item_t   pending_reqs[$];     // transactions not yet offered
    rsp_item_t   ring_results_due[$]; // predicted responses, oldest first
    int unsigned mismatch_cnt;
    int unsigned rsp_seen;
    int unsigned cycle_cnt;
    logic        req_took;            // request accepted at the last rising edge

    // Sender burst shaping
    int          burst_left;
    int          gap_left;

    // Receiver stall shaping
    int          hold_left;
    logic        long_hold_done;
    logic [9:0]  stall_phase;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: presents the next pending transaction on the falling edge.
    // Valid holds with a stable payload until the block takes it; between
    // bursts of random length the sender idles for a random gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_took))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left = burst_left - 1;
                else if ($urandom_range(7) == 0)
                begin
                    // long back-to-back stretch
                    burst_left = 100;
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotates through stall patterns. Once, with the sender still
    // busy, it holds off for long enough that the output register fills and
    // the block stops taking requests.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (!long_hold_done && rsp_seen >= 200 && pending_reqs.size() > 10)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            rsp_ready <= 1'b0;
        end
        else
        begin
            stall_phase = stall_phase + 1;
            case (stall_phase[9:8])
                2'd0:    rsp_ready <= 1'b1;
                2'd1:    rsp_ready <= ($urandom_range(3) != 0);
                2'd2:    rsp_ready <= ($urandom_range(3) == 0);
                default: rsp_ready <= (stall_phase[2:0] != 3'b111);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, predicts every accepted request and
    // checks every accepted response against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_item_t due;
        if (rst_n)
        begin
            cycle_cnt = cycle_cnt + 1;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                req_took = req_valid && req_ready;
                if (req_took)
                    ring_results_due.push_back(ring_transfer(req));
                if (rsp_valid && rsp_ready)
                begin
                    rsp_seen = rsp_seen + 1;
                    if (ring_results_due.size() == 0)
                    begin
                        mismatch_cnt = mismatch_cnt + 1;
                        $display("%0t: unexpected response, got %h", $time, rsp);
                    end
                    else
                    begin
                        due = ring_results_due.pop_front();
                        if (rsp.status !== due.status)
                        begin
                            mismatch_cnt = mismatch_cnt + 1;
                            $display("%0t: status expected %0d got %0d",
                                     $time, due.status, rsp.status);
                        end
                        if (rsp.read_bytes !== due.read_bytes)
                        begin
                            mismatch_cnt = mismatch_cnt + 1;
                            $display("%0t: read_bytes expected %h got %h",
                                     $time, due.read_bytes, rsp.read_bytes);
                        end
                        if (rsp.fill_level !== due.fill_level)
                        begin
                            mismatch_cnt = mismatch_cnt + 1;
                            $display("%0t: fill_level expected %0d got %0d",
                                     $time, due.fill_level, rsp.fill_level);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(logic op, int len, logic [DATA_W-1:0] data);
        req_item_t t;
        t.op          = op;
        t.length      = LEN_W'(len);
        t.write_bytes = data;
        pending_reqs.push_back(t);
    endtask

    function automatic logic [DATA_W-1:0] rand_bytes();
        return {$urandom, $urandom};
    endfunction

    // Waits until every queued transaction has been offered and answered.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || ring_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Ring size writes happen only with the block idle; they empty the ring.
    task automatic set_ring(logic [CFG_W-1:0] v);
        wait_idle();
        repeat (SETTLE) @(negedge clk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        ring_cfg  = v;
        head_ptr  = 0;
        tail_ptr  = 0;
    endtask

    // Random traffic in runs that lean toward writes or toward reads, so the
    // ring swings between full and empty and both pointers wrap. Halfway
    // through, the sender pauses until every response is back.
    task automatic gen_mix(int n, int unsigned slots);
        int run_left;
        int wr_pct;
        int len;
        int lim;
        run_left = 0;
        wr_pct   = 50;
        lim      = (slots < MAX_BYTES_DEF) ? slots : MAX_BYTES_DEF;
        for (int i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(4, 20);
                case ($urandom_range(2))
                    0:       wr_pct = 80;
                    1:       wr_pct = 25;
                    default: wr_pct = 50;
                endcase
            end
            run_left = run_left - 1;
            if ($urandom_range(19) == 0)
                len = $urandom_range(MAX_BYTES_DEF + 1, 15);
            else
                len = $urandom_range(0, lim);
            queue_item(($urandom_range(99) < wr_pct) ? OP_WRITE : OP_READ, len, rand_bytes());
            if (i == n / 2)
                wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] mix_sizes [13];
        mix_sizes = '{13'd3, 13'd1, 13'd5, 13'd8, 13'd16, 13'd0, 13'd37,
                      13'd100, 13'd255, 13'd4097, 13'd13, 13'd2, 13'd4096};

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_took       = 1'b0;
        mismatch_cnt   = 0;
        rsp_seen       = 0;
        cycle_cnt      = 0;
        burst_left     = 0;
        gap_left       = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        stall_phase    = '0;
        ring_cfg       = CFG_W'(DEPTH_DEF);
        head_ptr       = 0;
        tail_ptr       = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset ring size, empty ring, zero length, oversize lengths
        queue_item(OP_WRITE, 0, rand_bytes());
        queue_item(OP_READ, 0, '0);
        queue_item(OP_READ, 1, '0);                  // nothing stored
        queue_item(OP_WRITE, 8, '1);
        queue_item(OP_WRITE, 8, '0);
        queue_item(OP_WRITE, 9, rand_bytes());       // above MAX_BYTES
        queue_item(OP_READ, 15, '0);
        queue_item(OP_WRITE, 15, '1);
        queue_item(OP_READ, 8, '0);
        queue_item(OP_READ, 3, '0);
        queue_item(OP_READ, 5, '0);
        queue_item(OP_READ, 8, '0);                  // empty again

        // Smallest ring: one usable byte
        set_ring(13'd2);
        queue_item(OP_WRITE, 1, 64'hA5);
        queue_item(OP_WRITE, 1, 64'h5A);             // full
        queue_item(OP_READ, 2, '0);
        queue_item(OP_READ, 1, '0);

        // Sizes below 2 clamp to 2
        set_ring(13'd0);
        queue_item(OP_WRITE, 2, rand_bytes());
        queue_item(OP_WRITE, 1, rand_bytes());
        set_ring(13'd1);
        queue_item(OP_WRITE, 1, rand_bytes());
        queue_item(OP_READ, 1, '0);

        // Nine slots: a full burst fills it, then the pointers wrap
        set_ring(13'd9);
        queue_item(OP_WRITE, 8, rand_bytes());
        queue_item(OP_WRITE, 1, rand_bytes());
        queue_item(OP_READ, 4, '0);
        queue_item(OP_WRITE, 4, rand_bytes());
        queue_item(OP_READ, 8, '0);

        // Random traffic across ring sizes
        foreach (mix_sizes[k])
        begin
            set_ring(mix_sizes[k]);
            gen_mix(70, ring_slots());
        end

        // Largest register value clamps to DEPTH: fill the whole ring to 4095
        // bytes, then wrap the write pointer past the end.
        set_ring(13'h1FFF);
        for (int i = 0; i < (DEPTH_DEF - 8) / 8; i++)
            queue_item(OP_WRITE, 8, rand_bytes());
        queue_item(OP_WRITE, 7, rand_bytes());
        queue_item(OP_WRITE, 1, rand_bytes());       // full
        queue_item(OP_READ, 8, '0);
        queue_item(OP_WRITE, 8, rand_bytes());
        gen_mix(40, ring_slots());

        set_ring(CFG_W'(DEPTH_DEF));
        gen_mix(60, ring_slots());

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
